/* hdl/color_replace_blend_defines.svh */
// Assertion macros used by the checker file of color_replace_blend.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef COLOR_REPLACE_BLEND_DEFINES_SVH
`define COLOR_REPLACE_BLEND_DEFINES_SVH

// Same-cycle implication
`define CRB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CRB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/crb_pkg.sv */
// Package for color_replace_blend: item types, register indexes, widths.
// No dependencies; used by the top level and its checker.
package crb_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEW_RED      = 3'd0,
        REG_NEW_GREEN    = 3'd1,
        REG_NEW_BLUE     = 3'd2,
        REG_OLD_RED      = 3'd3,
        REG_OLD_GREEN    = 3'd4,
        REG_OLD_BLUE     = 3'd5,
        REG_MATCH_RADIUS = 3'd6
    } cfg_reg_t;

    // Datapath widths: distance and threshold (scaled by 512), blend numerator
    localparam int D_W     = 29;
    localparam int T_W     = 29;
    localparam int NUM_W   = 37;
    localparam int Q_W     = 8;
    localparam int NCHAN   = 3;
    localparam int NSTEP   = 8;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
        logic [7:0] in_alpha;
        logic       in_last;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
        logic       replaced;
        logic       out_last;
    } pix_out_t;

endpackage

/* hdl/color_replace_blend.sv */
// color_replace_blend: redmean color match and blend toward a new color.
// Depends on crb_pkg (item types, register indexes, widths).
//
//   channel   direction  handshake              payload
//   pixel     in         pix_valid / pix_stall  pix_data  (pix_in_t)
//   result    out        res_valid / res_stall  res_data  (pix_out_t)
//   config    in         cfg_write              cfg_index, cfg_data
//
// One item per cycle sustained unless res_stall holds the result with every stage full.
// Stages: 4 for the distance and threshold compare, 2 for the blend
// products and sum, 8 restoring-divider steps (one quotient bit each, three
// channels side by side), 1 output register.
// Reset clears all valid bits and the color/radius registers; no memories.
// A stalled result holds; an empty stage keeps filling, so bubbles close up.
module color_replace_blend
    import crb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_in_t               pix_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output pix_out_t              res_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG    = 15;
    localparam int DIV_STG = 7;   // first divider stage

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] new_red_reg, new_green_reg, new_blue_reg;
    logic [7:0] old_red_reg, old_green_reg, old_blue_reg;
    logic [9:0] match_radius_reg;
    logic [7:0] new_red_next, new_green_next, new_blue_next;
    logic [7:0] old_red_next, old_green_next, old_blue_next;
    logic [9:0] match_radius_next;

    // Decode a write; unknown indexes leave everything as is
    always_comb
    begin
        new_red_next      = new_red_reg;
        new_green_next    = new_green_reg;
        new_blue_next     = new_blue_reg;
        old_red_next      = old_red_reg;
        old_green_next    = old_green_reg;
        old_blue_next     = old_blue_reg;
        match_radius_next = match_radius_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NEW_RED:      new_red_next      = cfg_data[7:0];
                REG_NEW_GREEN:    new_green_next    = cfg_data[7:0];
                REG_NEW_BLUE:     new_blue_next     = cfg_data[7:0];
                REG_OLD_RED:      old_red_next      = cfg_data[7:0];
                REG_OLD_GREEN:    old_green_next    = cfg_data[7:0];
                REG_OLD_BLUE:     old_blue_next     = cfg_data[7:0];
                REG_MATCH_RADIUS: match_radius_next = cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_red_reg      <= '0;
            new_green_reg    <= '0;
            new_blue_reg     <= '0;
            old_red_reg      <= '0;
            old_green_reg    <= '0;
            old_blue_reg     <= '0;
            match_radius_reg <= '0;
        end
        else
        begin
            new_red_reg      <= new_red_next;
            new_green_reg    <= new_green_next;
            new_blue_reg     <= new_blue_next;
            old_red_reg      <= old_red_next;
            old_green_reg    <= old_green_next;
            old_blue_reg     <= old_blue_next;
            match_radius_reg <= match_radius_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when it or any stage after
    // it is empty, or when the result is taken
    // ------------------------------------------------------------------
    logic [NSTG:1] valid_reg;
    logic [NSTG:1] adv;

    for (genvar k = 1; k <= NSTG; k++)
    begin : g_adv
        assign adv[k] = !res_stall || !(&valid_reg[NSTG:k]);
    end

    assign pix_stall = !adv[1];
    assign res_valid = valid_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= pix_valid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: channel differences, their squares, red sum, radius squared
    // ------------------------------------------------------------------
    logic signed [8:0]  s1_dr, s1_dg, s1_db;
    logic signed [17:0] s1_dr2_full, s1_dg2_full, s1_db2_full;
    logic [15:0]        s1_dr2_next, s1_dg2_next, s1_db2_next;
    logic [8:0]         s1_rsum_next;
    logic [19:0]        s1_rad2_next;
    pix_in_t            s1_pix_reg;
    logic [15:0]        s1_dr2_reg, s1_dg2_reg, s1_db2_reg;
    logic [8:0]         s1_rsum_reg;
    logic [19:0]        s1_rad2_reg;

    assign s1_dr = $signed({1'b0, pix_data.in_red})   - $signed({1'b0, old_red_reg});
    assign s1_dg = $signed({1'b0, pix_data.in_green}) - $signed({1'b0, old_green_reg});
    assign s1_db = $signed({1'b0, pix_data.in_blue})  - $signed({1'b0, old_blue_reg});
    assign s1_dr2_full  = s1_dr * s1_dr;
    assign s1_dg2_full  = s1_dg * s1_dg;
    assign s1_db2_full  = s1_db * s1_db;
    assign s1_dr2_next  = s1_dr2_full[15:0];
    assign s1_dg2_next  = s1_dg2_full[15:0];
    assign s1_db2_next  = s1_db2_full[15:0];
    assign s1_rsum_next = {1'b0, pix_data.in_red} + {1'b0, old_red_reg};
    assign s1_rad2_next = 20'(match_radius_reg) * 20'(match_radius_reg);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_pix_reg  <= pix_data;
            s1_dr2_reg  <= s1_dr2_next;
            s1_dg2_reg  <= s1_dg2_next;
            s1_db2_reg  <= s1_db2_next;
            s1_rsum_reg <= s1_rsum_next;
            s1_rad2_reg <= s1_rad2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: redmean cross term and the weighted sum of squares
    // ------------------------------------------------------------------
    logic signed [16:0] s2_sqdiff;
    logic signed [26:0] s2_prod_next;
    logic [D_W-1:0]     s2_sum_next;
    logic [T_W-1:0]     s2_t_next;
    pix_in_t            s2_pix_reg;
    logic signed [26:0] s2_prod_reg;
    logic [D_W-1:0]     s2_sum_reg;
    logic [T_W-1:0]     s2_t_reg;

    assign s2_sqdiff    = $signed({1'b0, s1_dr2_reg}) - $signed({1'b0, s1_db2_reg});
    assign s2_prod_next = $signed({1'b0, s1_rsum_reg}) * s2_sqdiff;
    // 1024*dr2 + 2048*dg2 + 1536*db2
    assign s2_sum_next  = D_W'({s1_dr2_reg, 10'b0}) + D_W'({s1_dg2_reg, 11'b0})
                        + D_W'({s1_db2_reg, 10'b0}) + D_W'({s1_db2_reg, 9'b0});
    assign s2_t_next    = {s1_rad2_reg, 9'b0};

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_pix_reg  <= s1_pix_reg;
            s2_prod_reg <= s2_prod_next;
            s2_sum_reg  <= s2_sum_next;
            s2_t_reg    <= s2_t_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: distance; the cross term never outweighs the sum, so D >= 0
    // ------------------------------------------------------------------
    logic signed [D_W:0] s3_d_full;
    pix_in_t             s3_pix_reg;
    logic [D_W-1:0]      s3_d_reg;
    logic [T_W-1:0]      s3_t_reg;

    assign s3_d_full = $signed({1'b0, s2_sum_reg}) + (D_W+1)'(s2_prod_reg);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_pix_reg <= s2_pix_reg;
            s3_d_reg   <= s3_d_full[D_W-1:0];
            s3_t_reg   <= s2_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: threshold compare and blend weight T - D
    // ------------------------------------------------------------------
    logic           s4_hit_next;
    logic [T_W-1:0] s4_tmd_next;
    pix_in_t        s4_pix_reg;
    logic           s4_hit_reg;
    logic [T_W-1:0] s4_tmd_reg;
    logic [D_W-1:0] s4_d_reg;
    logic [T_W-1:0] s4_t_reg;

    assign s4_hit_next = (s3_t_reg != '0) && (s3_d_reg < s3_t_reg);
    assign s4_tmd_next = s3_t_reg - s3_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_pix_reg <= s3_pix_reg;
            s4_hit_reg <= s4_hit_next;
            s4_tmd_reg <= s4_tmd_next;
            s4_d_reg   <= s3_d_reg;
            s4_t_reg   <= s3_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: blend products new*(T-D) and src*D per channel
    // (channel 0 blue, 1 green, 2 red)
    // ------------------------------------------------------------------
    logic [7:0]       s5_new [NCHAN];
    logic [7:0]       s5_src [NCHAN];
    logic [NUM_W-1:0] s5_pn_next [NCHAN];
    logic [NUM_W-1:0] s5_ps_next [NCHAN];
    pix_in_t          s5_pix_reg;
    logic             s5_hit_reg;
    logic [T_W-1:0]   s5_t_reg;
    logic [NUM_W-1:0] s5_pn_reg [NCHAN];
    logic [NUM_W-1:0] s5_ps_reg [NCHAN];

    assign s5_new[0] = new_blue_reg;
    assign s5_new[1] = new_green_reg;
    assign s5_new[2] = new_red_reg;
    assign s5_src[0] = s4_pix_reg.in_blue;
    assign s5_src[1] = s4_pix_reg.in_green;
    assign s5_src[2] = s4_pix_reg.in_red;

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            s5_pn_next[c] = NUM_W'(s5_new[c]) * NUM_W'(s4_tmd_reg);
            s5_ps_next[c] = NUM_W'(s5_src[c]) * NUM_W'(s4_d_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_pix_reg <= s4_pix_reg;
            s5_hit_reg <= s4_hit_reg;
            s5_t_reg   <= s4_t_reg;
            for (int c = 0; c < NCHAN; c++)
            begin
                s5_pn_reg[c] <= s5_pn_next[c];
                s5_ps_reg[c] <= s5_ps_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: blend numerators
    // ------------------------------------------------------------------
    pix_in_t          s6_pix_reg;
    logic             s6_hit_reg;
    logic [T_W-1:0]   s6_t_reg;
    logic [NUM_W-1:0] s6_num_reg [NCHAN];

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_pix_reg <= s5_pix_reg;
            s6_hit_reg <= s5_hit_reg;
            s6_t_reg   <= s5_t_reg;
            for (int c = 0; c < NCHAN; c++)
            begin
                s6_num_reg[c] <= s5_pn_reg[c] + s5_ps_reg[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 7..14: restoring divide by T, one quotient bit per stage,
    // most significant bit first
    // ------------------------------------------------------------------
    pix_in_t          dv_pix_reg [NSTEP];
    logic             dv_hit_reg [NSTEP];
    logic [T_W-1:0]   dv_t_reg   [NSTEP];
    logic [NUM_W-1:0] dv_rem_reg [NSTEP][NCHAN];
    logic [Q_W-1:0]   dv_q_reg   [NSTEP][NCHAN];
    logic [T_W-1:0]   dv_t_in    [NSTEP];
    logic [NUM_W-1:0] dv_rem_in  [NSTEP][NCHAN];
    logic [Q_W-1:0]   dv_q_in    [NSTEP][NCHAN];
    logic [NUM_W-1:0] dv_rem_next [NSTEP][NCHAN];
    logic [Q_W-1:0]   dv_q_next   [NSTEP][NCHAN];

    // Select each step's inputs: numerator for the first, previous step after
    always_comb
    begin
        for (int j = 0; j < NSTEP; j++)
        begin
            for (int c = 0; c < NCHAN; c++)
            begin
                if (j == 0)
                begin
                    dv_rem_in[j][c] = s6_num_reg[c];
                    dv_q_in[j][c]   = '0;
                end
                else
                begin
                    dv_rem_in[j][c] = dv_rem_reg[j-1][c];
                    dv_q_in[j][c]   = dv_q_reg[j-1][c];
                end
            end
            dv_t_in[j] = (j == 0) ? s6_t_reg : dv_t_reg[j-1];
        end
    end

    // Compare and subtract the shifted divisor
    always_comb
    begin
        logic [NUM_W-1:0] tsh;
        logic             ge;
        tsh = '0;
        ge  = 1'b0;
        for (int j = 0; j < NSTEP; j++)
        begin
            tsh = NUM_W'(dv_t_in[j]) << (NSTEP - 1 - j);
            for (int c = 0; c < NCHAN; c++)
            begin
                ge                = (dv_rem_in[j][c] >= tsh);
                dv_rem_next[j][c] = ge ? (dv_rem_in[j][c] - tsh) : dv_rem_in[j][c];
                dv_q_next[j][c]   = {dv_q_in[j][c][Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NSTEP; j++)
        begin
            if (adv[DIV_STG + j])
            begin
                dv_pix_reg[j] <= (j == 0) ? s6_pix_reg : dv_pix_reg[j-1];
                dv_hit_reg[j] <= (j == 0) ? s6_hit_reg : dv_hit_reg[j-1];
                dv_t_reg[j]   <= dv_t_in[j];
                for (int c = 0; c < NCHAN; c++)
                begin
                    dv_rem_reg[j][c] <= dv_rem_next[j][c];
                    dv_q_reg[j][c]   <= dv_q_next[j][c];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 15: pick blended or source pixel
    // ------------------------------------------------------------------
    pix_out_t res_next;
    pix_out_t res_reg;

    always_comb
    begin
        res_next.out_last = dv_pix_reg[NSTEP-1].in_last;
        if (dv_hit_reg[NSTEP-1])
        begin
            res_next.out_blue  = dv_q_reg[NSTEP-1][0];
            res_next.out_green = dv_q_reg[NSTEP-1][1];
            res_next.out_red   = dv_q_reg[NSTEP-1][2];
            res_next.out_alpha = ALPHA_OPAQUE;
            res_next.replaced  = 1'b1;
        end
        else
        begin
            res_next.out_blue  = dv_pix_reg[NSTEP-1].in_blue;
            res_next.out_green = dv_pix_reg[NSTEP-1].in_green;
            res_next.out_red   = dv_pix_reg[NSTEP-1].in_red;
            res_next.out_alpha = dv_pix_reg[NSTEP-1].in_alpha;
            res_next.replaced  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NSTG])
        begin
            res_reg <= res_next;
        end
    end

    assign res_data = res_reg;

endmodule

/* hdl/crb_checker.sv */
// Port-level checks for color_replace_blend, bound to the top level.
// Depends on crb_pkg and color_replace_blend_defines.svh.
`include "color_replace_blend_defines.svh"

module crb_checker
    import crb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pix_valid,
    input logic                  pix_stall,
    input pix_in_t               pix_data,
    input logic                  res_valid,
    input logic                  res_stall,
    input pix_out_t              res_data,
    input logic                  cfg_write,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    logic radius_zero_reg;
    logic radius_zero_next;
    logic pix_seen;

    // Track whether the radius register currently holds zero
    always_comb
    begin
        radius_zero_next = radius_zero_reg;
        if (cfg_write && (cfg_reg_t'(cfg_index) == REG_MATCH_RADIUS))
        begin
            radius_zero_next = (cfg_data == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_zero_reg <= 1'b1;
        end
        else
        begin
            radius_zero_reg <= radius_zero_next;
        end
    end

    assign pix_seen = pix_valid && (pix_data.in_last || !pix_data.in_last);

    // Input back-pressure only comes from a held result
    `CRB_ASSERT_IMP(a_stall_source, pix_stall, res_valid && res_stall, "pixel stall without held result")
    // A replaced pixel is always opaque
    `CRB_ASSERT_IMP(a_replaced_alpha, res_valid && res_data.replaced, res_data.out_alpha == ALPHA_OPAQUE, "replaced pixel not opaque")
    // Zero radius disables replacement
    `CRB_ASSERT_IMP(a_zero_radius, res_valid && res_data.replaced, !radius_zero_reg, "replacement with zero radius")
    // A stalled result holds
    `CRB_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data), "stalled result changed")
    // An idle pipeline never stalls an offered pixel
    `CRB_ASSERT_IMP(a_idle_accept, pix_seen && !res_valid, !pix_stall, "pixel stalled while output empty")

endmodule

bind color_replace_blend crb_checker u_crb_checker (.*);
